>>> design/tuner_rf_tune_sequence_unit_defines.svh
// Assertion macros shared by the tune sequencer modules.
// Each one samples on clk and is off while rst is high.
`ifndef TUNER_RF_TUNE_SEQUENCE_UNIT_DEFINES_SVH
`define TUNER_RF_TUNE_SEQUENCE_UNIT_DEFINES_SVH

// Check holds in the same cycle as the trigger
`define TRS_ASSERT_NOW(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

// Check holds in the cycle after the trigger
`define TRS_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

`endif

>>> design/trs_pkg.sv
package trs_pkg;

  // Field widths
  localparam int FREQ_W = 30;
  localparam int BW_W   = 8;
  localparam int BYTE_W = 8;
  localparam int CODE_W = 6;
  localparam int WORD_W = 16;
  localparam int REM_W  = 20;
  localparam int Q_W    = 11;

  // Division by one million: multiply by a rounded-up reciprocal, keep top bits
  localparam int RECIP_SHIFT = 50;
  localparam int RECIP_W     = 31;
  localparam int PROD_W      = FREQ_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M   = 31'd1125899907;
  localparam logic [REM_W-1:0]   FREQ_UNIT = 20'd1000000;

  // Fractional steps in 1/64 MHz, strict compare against halving divisors
  localparam int N_STEPS = 6;
  localparam logic [REM_W-1:0] STEP_DIV [N_STEPS] = '{
    20'd500000, 20'd250000, 20'd125000, 20'd62500, 20'd31250, 20'd15625
  };
  localparam logic [REM_W-1:0]  ROUND_LIMIT  = 20'd7812;
  localparam logic [FREQ_W-1:0] HIGH_BAND_HZ = 30'd333000000;

  // Bandwidth selection
  localparam logic [BW_W-1:0]   BW_6MHZ  = 8'd6;
  localparam logic [BW_W-1:0]   BW_7MHZ  = 8'd7;
  localparam logic [BW_W-1:0]   BW_8MHZ  = 8'd8;
  localparam logic [CODE_W-1:0] CODE_BW6 = 6'h15;
  localparam logic [CODE_W-1:0] CODE_BW7 = 6'h2A;
  localparam logic [CODE_W-1:0] CODE_BW8 = 6'h3F;

  // Tuner register addresses
  localparam logic [BYTE_W-1:0] ADDR_CTRL    = 8'h0F;
  localparam logic [BYTE_W-1:0] ADDR_BW      = 8'h0C;
  localparam logic [BYTE_W-1:0] ADDR_FREQ_LO = 8'h0D;
  localparam logic [BYTE_W-1:0] ADDR_FREQ_HI = 8'h0E;
  localparam logic [BYTE_W-1:0] ADDR_OVR_A0  = 8'h1F;
  localparam logic [BYTE_W-1:0] ADDR_OVR_B0  = 8'h20;
  localparam logic [BYTE_W-1:0] ADDR_OVR_A1  = 8'h21;
  localparam logic [BYTE_W-1:0] ADDR_OVR_B1  = 8'h22;
  localparam logic [BYTE_W-1:0] ADDR_BAND    = 8'h80;

  // Register data values
  localparam logic [BYTE_W-1:0] DATA_ABORT    = 8'h00;
  localparam logic [BYTE_W-1:0] DATA_START    = 8'h01;
  localparam logic [BYTE_W-1:0] DATA_OVR_A    = 8'h87;
  localparam logic [BYTE_W-1:0] DATA_OVR_B    = 8'h1F;
  localparam logic [BYTE_W-1:0] BAND_LOW      = 8'h01;
  localparam logic [BYTE_W-1:0] HIGH_BAND_BIT = 8'h40;
  localparam logic [BYTE_W-1:0] BAND_HIGH     = BAND_LOW | HIGH_BAND_BIT;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  // One classified tune request
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CODE_W-1:0] code;
    logic              high_band;
  } tune_t;

  // Write sequence steps
  typedef enum logic [3:0] {
    W_ABORT,
    W_BW,
    W_FREQ_LO,
    W_FREQ_HI,
    W_OVR_A0,
    W_OVR_B0,
    W_OVR_A1,
    W_OVR_B1,
    W_BAND,
    W_START
  } write_step_t;

endpackage

>>> design/trs_front.sv
module trs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [trs_pkg::FREQ_W-1:0]   rf_freq_hz,
  input  logic [trs_pkg::BW_W-1:0]     bandwidth_mhz,
  input  logic                         q_full,
  output logic                         push,
  output trs_pkg::tune_t               push_item
);
  import trs_pkg::*;

  logic              adv;
  logic              acc;
  logic [CODE_W-1:0] bw_code;
  logic [CODE_W-1:0] bw_code_next;

  // Front stages: capture, reciprocal product, quotient, then remainder steps
  logic              v0, v1, v2;
  logic [FREQ_W-1:0] f0, f1, f2;
  logic [CODE_W-1:0] c0, c1, c2;
  logic [PROD_W-1:0] prod1;
  logic [Q_W-1:0]    q2;
  logic [FREQ_W-1:0] qm2;

  logic              sv    [N_STEPS+1];
  logic [REM_W-1:0]  srem  [N_STEPS+1];
  logic [WORD_W-1:0] sword [N_STEPS+1];
  logic [CODE_W-1:0] scode [N_STEPS+1];
  logic              shb   [N_STEPS+1];

  // Whole pipeline moves unless the last stage waits on a full queue
  assign adv      = !(sv[N_STEPS] && q_full);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // Bandwidth code follows valid requests only
  always_comb begin
    case (bandwidth_mhz)
      BW_6MHZ: bw_code_next = CODE_BW6;
      BW_7MHZ: bw_code_next = CODE_BW7;
      BW_8MHZ: bw_code_next = CODE_BW8;
      default: bw_code_next = bw_code;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bw_code <= CODE_BW6;
      v0      <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      for (int k = 0; k <= N_STEPS; k++) sv[k] <= 1'b0;
    end else begin
      if (acc) bw_code <= bw_code_next;
      if (adv) begin
        v0    <= in_valid;
        v1    <= v0;
        v2    <= v1;
        sv[0] <= v2;
        for (int k = 0; k < N_STEPS; k++) sv[k+1] <= sv[k];
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      f0    <= rf_freq_hz;
      c0    <= bw_code_next;
      prod1 <= PROD_W'(f0) * PROD_W'(RECIP_M);
      f1    <= f0;
      c1    <= c0;
      q2    <= prod1[PROD_W-1:RECIP_SHIFT];
      qm2   <= FREQ_W'(prod1[PROD_W-1:RECIP_SHIFT]) * FREQ_W'(FREQ_UNIT);
      f2    <= f1;
      c2    <= c1;
      // remainder is below 2^20, so the low bits of the difference are exact
      srem[0]  <= f2[REM_W-1:0] - qm2[REM_W-1:0];
      sword[0] <= WORD_W'(q2);
      scode[0] <= c2;
      shb[0]   <= f2 > HIGH_BAND_HZ;
      for (int k = 0; k < N_STEPS; k++) begin
        scode[k+1] <= scode[k];
        shb[k+1]   <= shb[k];
        if (srem[k] > STEP_DIV[k]) begin
          srem[k+1]  <= srem[k] - STEP_DIV[k];
          sword[k+1] <= {sword[k][WORD_W-2:0], 1'b1};
        end else begin
          srem[k+1]  <= srem[k];
          sword[k+1] <= {sword[k][WORD_W-2:0], 1'b0};
        end
      end
    end
  end

  // Round to nearest on the way into the queue
  assign push                = sv[N_STEPS] && !q_full;
  assign push_item.word      = sword[N_STEPS] + WORD_W'(srem[N_STEPS] > ROUND_LIMIT);
  assign push_item.code      = scode[N_STEPS];
  assign push_item.high_band = shb[N_STEPS];

endmodule

>>> design/trs_queue.sv
`include "tuner_rf_tune_sequence_unit_defines.svh"

module trs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  trs_pkg::tune_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output trs_pkg::tune_t q_item
);
  import trs_pkg::*;

  tune_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wptr;
  logic [QUEUE_AW-1:0]  rptr;
  logic [QUEUE_CW-1:0]  count;

  assign full    = count == QUEUE_CW'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_item  = mem[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  `TRS_ASSERT_NOW(a_no_overflow, push, !full || pop, "queue push while full")
  `TRS_ASSERT_NOW(a_no_underflow, pop, q_valid, "queue pop while empty")
  `TRS_ASSERT_NOW(a_count_range, 1'b1, count <= QUEUE_CW'(QUEUE_DEPTH), "queue count out of range")

endmodule

>>> design/trs_back.sv
`include "tuner_rf_tune_sequence_unit_defines.svh"

module trs_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  trs_pkg::tune_t             q_item,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [trs_pkg::BYTE_W-1:0] reg_addr,
  output logic [trs_pkg::BYTE_W-1:0] reg_data,
  output logic                       last_write
);
  import trs_pkg::*;

  logic        busy, busy_next;
  write_step_t step, step_next;
  tune_t       cur;
  logic        out_fire;
  logic        done;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= W_ABORT;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

  // Current request
  always_ff @(posedge clk) begin
    if (pop) cur <= q_item;
  end

  // Sequencing: next request is loaded as the start write goes out, or while idle
  always_comb begin
    out_fire  = busy && !out_stall;
    done      = !busy || (out_fire && step == W_START);
    pop       = done && q_valid;
    busy_next = busy;
    step_next = step;
    if (pop) begin
      busy_next = 1'b1;
      step_next = W_ABORT;
    end else if (done) begin
      busy_next = 1'b0;
    end else if (out_fire) begin
      case (step)
        W_ABORT:   step_next = W_BW;
        W_BW:      step_next = W_FREQ_LO;
        W_FREQ_LO: step_next = W_FREQ_HI;
        W_FREQ_HI: step_next = W_OVR_A0;
        W_OVR_A0:  step_next = W_OVR_B0;
        W_OVR_B0:  step_next = W_OVR_A1;
        W_OVR_A1:  step_next = W_OVR_B1;
        W_OVR_B1:  step_next = W_BAND;
        W_BAND:    step_next = W_START;
        default:   step_next = W_ABORT;
      endcase
    end
  end

  // Write decode from the held step and request
  always_comb begin
    out_valid  = busy;
    last_write = 1'b0;
    case (step)
      W_ABORT: begin
        reg_addr = ADDR_CTRL;
        reg_data = DATA_ABORT;
      end
      W_BW: begin
        reg_addr = ADDR_BW;
        reg_data = BYTE_W'(cur.code);
      end
      W_FREQ_LO: begin
        reg_addr = ADDR_FREQ_LO;
        reg_data = cur.word[BYTE_W-1:0];
      end
      W_FREQ_HI: begin
        reg_addr = ADDR_FREQ_HI;
        reg_data = cur.word[WORD_W-1:BYTE_W];
      end
      W_OVR_A0: begin
        reg_addr = ADDR_OVR_A0;
        reg_data = DATA_OVR_A;
      end
      W_OVR_B0: begin
        reg_addr = ADDR_OVR_B0;
        reg_data = DATA_OVR_B;
      end
      W_OVR_A1: begin
        reg_addr = ADDR_OVR_A1;
        reg_data = DATA_OVR_A;
      end
      W_OVR_B1: begin
        reg_addr = ADDR_OVR_B1;
        reg_data = DATA_OVR_B;
      end
      W_BAND: begin
        reg_addr = ADDR_BAND;
        reg_data = cur.high_band ? BAND_HIGH : BAND_LOW;
      end
      W_START: begin
        reg_addr   = ADDR_CTRL;
        reg_data   = DATA_START;
        last_write = 1'b1;
      end
      default: begin
        reg_addr = ADDR_CTRL;
        reg_data = DATA_ABORT;
      end
    endcase
  end

  `TRS_ASSERT_NOW(a_last_is_start, out_valid && last_write, reg_addr == ADDR_CTRL && reg_data == DATA_START, "last write is not start tune")
  `TRS_ASSERT_NOW(a_pop_at_end, pop, !busy || step == W_START, "request loaded mid-sequence")
  `TRS_ASSERT_NEXT(a_idle_after_last, out_fire && last_write && !q_valid, !out_valid, "writes continue past last")

endmodule

>>> design/tuner_rf_tune_sequence_unit.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    rf_freq_hz[29:0], bandwidth_mhz[7:0]
// out      out_valid / out_stall  reg_addr[7:0], reg_data[7:0], last_write
//
// Ten writes per request, one per cycle while out_stall is low; the write
// sequencer sets the sustained request rate.
// Before its first write is offered, a request passes in order through multiply,
// quotient, remainder, six compare-subtract stages, queue write, sequencer load.
// rst (synchronous) clears stage flags and the queue, bandwidth code to 6 MHz.
// out_stall holds the write; in_stall only while the last stage meets a full queue.
module tuner_rf_tune_sequence_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [trs_pkg::FREQ_W-1:0] rf_freq_hz,
  input  logic [trs_pkg::BW_W-1:0]   bandwidth_mhz,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [trs_pkg::BYTE_W-1:0] reg_addr,
  output logic [trs_pkg::BYTE_W-1:0] reg_data,
  output logic                       last_write
);
  import trs_pkg::*;

  logic  push;
  tune_t push_item;
  logic  full;
  logic  pop;
  logic  q_valid;
  tune_t q_item;

  // Front: bandwidth code and frequency word
  trs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rf_freq_hz    (rf_freq_hz),
    .bandwidth_mhz (bandwidth_mhz),
    .q_full        (full),
    .push          (push),
    .push_item     (push_item)
  );

  // Request queue
  trs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Back: register write sequencer
  trs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_addr   (reg_addr),
    .reg_data   (reg_data),
    .last_write (last_write)
  );

endmodule
